FILE: sv/gtp_pkg.sv
// gtp_pkg: shared types and constants for the gelu tanh pade core
// word structs, pipeline widths and fixed-point coefficients
// no dependencies
package gtp_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] activation;
        logic               last_out;
    } out_word_t;

    typedef struct packed {
        logic               neg;
        logic signed [15:0] sample;
        logic               last;
    } div_side_t;

    localparam int NUM_W = 58;
    localparam int DEN_W = 41;
    localparam int QUO_W = 18;

    localparam logic signed [12:0] GELU_CUBE_COEF = 13'sd2930;
    localparam logic signed [16:0] GELU_SCALE     = 17'sd52290;
    localparam logic [16:0]        ONE_Q16        = 17'd65536;

    localparam logic [24:0] P1_K = 25'(378 * 65536);
    localparam logic [31:0] P2_K = 32'(17325 * 65536);
    localparam logic [37:0] P3_K = 38'(64'd135135 * 64'd65536);
    localparam logic [28:0] Q1_K = 29'(3150 * 65536);
    localparam logic [34:0] Q2_K = 35'(64'd62370 * 64'd65536);
    localparam logic [40:0] Q3_K = 41'(64'd135135 * 64'd65536);

endpackage

FILE: sv/gelu_tanh_pade_core.sv
// gelu_tanh_pade_core: from input accept to m_valid the word passes
// 12 polynomial stages, 18 divider stages, 2 output stages
// throughput one word per cycle when m_ready stays high; every stage
// holds its own valid bit so bubbles close up under output stall
// reset clears all valid bits, data registers are not reset
// depends on gtp_pkg and gtp_div
module gelu_tanh_pade_core import gtp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int NST = 12;

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;
    logic signed [15:0] samp_reg [NST];
    logic               last_reg [NST];

    logic               div_ready;
    logic               div_valid;
    logic [QUO_W-1:0]   div_quot;
    div_side_t          div_side_in;
    div_side_t          div_side_out;

    // stage payloads
    logic signed [11:0] sc_next;
    logic signed [11:0] sc0_reg, sc1_reg, sc2_reg;
    logic signed [23:0] sq0_reg;
    logic signed [35:0] cube1_reg;
    logic signed [47:0] cc2_reg;
    logic signed [47:0] inner_sum;
    logic signed [23:0] inner3_reg;
    logic signed [40:0] um4_reg;
    logic signed [24:0] ush;
    logic signed [20:0] u_next;
    logic signed [20:0] u5_reg, u6_reg, u7_reg, u8_reg, u9_reg;
    logic signed [41:0] uu;
    logic [22:0]        u2_6_reg, u2_7_reg, u2_8_reg;
    logic [24:0]        p7_reg;
    logic [28:0]        q7_reg;
    logic [47:0]        pm8;
    logic [51:0]        qm8;
    logic [31:0]        p8_reg;
    logic [34:0]        q8_reg;
    logic [54:0]        pm9;
    logic [57:0]        qm9;
    logic [37:0]        p9_reg;
    logic [40:0]        q9_reg, q10_reg, q11_reg;
    logic signed [59:0] nm10;
    logic signed [41:0] num10_reg;
    logic [40:0]        mag;
    logic [NUM_W-1:0]   n11_reg;
    logic               neg11_reg;

    // output stages
    logic               va_reg;
    logic               vb_reg;
    logic               en_a;
    logic               en_b;
    logic [16:0]        tmag;
    logic [17:0]        f_next;
    logic signed [34:0] prod_a_reg;
    logic               last_a_reg;
    logic signed [35:0] ysum;
    logic signed [18:0] ysh;
    out_word_t          m_word_reg;
    out_word_t          m_word_next;

    assign s_ready = en[0];

    for (genvar i = 0; i < NST; i++) begin : g_ctl
        if (i == NST-1) begin : g_en_last
            assign en[i] = !v_reg[i] || div_ready;
        end else begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en[i]) begin
                v_reg[i] <= (i == 0) ? s_valid : v_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                samp_reg[i] <= (i == 0) ? s_word.sample  : samp_reg[(i == 0) ? 0 : i-1];
                last_reg[i] <= (i == 0) ? s_word.last_in : last_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // beyond |x| = 8 the tanh argument clamps anyway
    always_comb begin
        if (s_word.sample > 16'sd2047) begin
            sc_next = 12'sd2047;
        end else if (s_word.sample < -16'sd2048) begin
            sc_next = -12'sd2048;
        end else begin
            sc_next = s_word.sample[11:0];
        end
    end

    assign inner_sum = (48'(sc2_reg) <<< 32) + cc2_reg;
    assign ush       = um4_reg[40:16];

    always_comb begin
        if (ush > 25'sd524288) begin
            u_next = 21'sd524288;
        end else if (ush < -25'sd524288) begin
            u_next = -21'sd524288;
        end else begin
            u_next = ush[20:0];
        end
    end

    assign uu   = u5_reg * u5_reg;
    assign pm8  = 48'(p7_reg) * 48'(u2_7_reg);
    assign qm8  = 52'(q7_reg) * 52'(u2_7_reg);
    assign pm9  = 55'(p8_reg) * 55'(u2_8_reg);
    assign qm9  = 58'(q8_reg) * 58'(u2_8_reg);
    assign nm10 = $signed({1'b0, p9_reg}) * u9_reg;
    assign mag  = num10_reg[41] ? 41'(-num10_reg) : num10_reg[40:0];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sc0_reg <= sc_next;
            sq0_reg <= sc_next * sc_next;
        end
        if (en[1]) begin
            sc1_reg   <= sc0_reg;
            cube1_reg <= sq0_reg * sc0_reg;
        end
        if (en[2]) begin
            sc2_reg <= sc1_reg;
            cc2_reg <= cube1_reg * GELU_CUBE_COEF;
        end
        if (en[3]) begin
            inner3_reg <= inner_sum[47:24];
        end
        if (en[4]) begin
            um4_reg <= inner3_reg * GELU_SCALE;
        end
        if (en[5]) begin
            u5_reg <= u_next;
        end
        if (en[6]) begin
            u6_reg   <= u5_reg;
            u2_6_reg <= uu[38:16];
        end
        if (en[7]) begin
            u7_reg   <= u6_reg;
            u2_7_reg <= u2_6_reg;
            p7_reg   <= P1_K + 25'(u2_6_reg);
            q7_reg   <= Q1_K + 29'(u2_6_reg) * 29'd28;
        end
        if (en[8]) begin
            u8_reg   <= u7_reg;
            u2_8_reg <= u2_7_reg;
            p8_reg   <= pm8[47:16] + P2_K;
            q8_reg   <= qm8[50:16] + Q2_K;
        end
        if (en[9]) begin
            u9_reg <= u8_reg;
            p9_reg <= pm9[53:16] + P3_K;
            q9_reg <= qm9[56:16] + Q3_K;
        end
        if (en[10]) begin
            num10_reg <= nm10[57:16];
            q10_reg   <= q9_reg;
        end
        if (en[11]) begin
            neg11_reg <= num10_reg[41];
            n11_reg   <= {mag, 16'b0} + NUM_W'(q10_reg >> 1);
            q11_reg   <= q10_reg;
        end
    end

    assign div_side_in.neg    = neg11_reg;
    assign div_side_in.sample = samp_reg[NST-1];
    assign div_side_in.last   = last_reg[NST-1];

    gtp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_reg[NST-1]),
        .in_ready  (div_ready),
        .in_num    (n11_reg),
        .in_den    (q11_reg),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .out_ready (en_a),
        .out_quot  (div_quot),
        .out_side  (div_side_out)
    );

    assign en_b = !vb_reg || m_ready;
    assign en_a = !va_reg || en_b;

    assign tmag   = (div_quot > QUO_W'(ONE_Q16)) ? ONE_Q16 : div_quot[16:0];
    assign f_next = div_side_out.neg ? 18'(ONE_Q16) - 18'(tmag)
                                     : 18'(ONE_Q16) + 18'(tmag);

    assign ysum = 36'(prod_a_reg) + 36'sd65536;
    assign ysh  = ysum[35:17];

    always_comb begin
        m_word_next.last_out = last_a_reg;
        if (ysh > 19'sd32767) begin
            m_word_next.activation = 16'sd32767;
        end else if (ysh < -19'sd32768) begin
            m_word_next.activation = -16'sd32768;
        end else begin
            m_word_next.activation = ysh[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= div_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            prod_a_reg <= div_side_out.sample * $signed({1'b0, f_next});
            last_a_reg <= div_side_out.last;
        end
        if (en_b) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = vb_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: sv/gtp_div.sv
// gtp_div: pipelined restoring divider, one quotient bit per stage
// carries a side word alongside each quotient
// depends on gtp_pkg
module gtp_div import gtp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  div_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quot,
    output div_side_t        out_side
);

    logic [QUO_W-1:0] v_reg;
    logic [QUO_W-1:0] en;
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] lo_reg   [QUO_W];
    logic [QUO_W-1:0] quot_reg [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    div_side_t        side_reg [QUO_W];

    assign in_ready  = en[0];
    assign out_valid = v_reg[QUO_W-1];
    assign out_quot  = quot_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] lo_in;
        logic [QUO_W-1:0] quot_in;
        logic [DEN_W-1:0] den_in;
        div_side_t        side_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign lo_in   = in_num[QUO_W-1:0];
            assign quot_in = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign lo_in   = lo_reg[j-1];
            assign quot_in = quot_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        if (j == QUO_W-1) begin : g_en_last
            assign en[j] = !v_reg[j] || out_ready;
        end else begin : g_en
            assign en[j] = !v_reg[j] || en[j+1];
        end

        assign trial    = {rem_in, lo_in[QUO_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en[j]) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j]  <= rem_next;
                lo_reg[j]   <= {lo_in[QUO_W-2:0], 1'b0};
                quot_reg[j] <= {quot_in[QUO_W-2:0], ge};
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

endmodule
